// File: design/qcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qcd_pkg: shared types, tag codes and helpers for the QOI chunk decoder
// Pixel and chunk types, tag constants, chunk length and index hash.
// ----------------------------------------------------------------------------
package qcd_pkg;

  localparam int unsigned TableDepth = 64;
  localparam int unsigned TableAw    = $clog2(TableDepth);

  localparam logic [7:0] TAG_RGB  = 8'hFE;
  localparam logic [7:0] TAG_RGBA = 8'hFF;

  // two-bit op codes in tag[7:6]
  localparam logic [1:0] OP_INDEX = 2'b00;
  localparam logic [1:0] OP_DIFF  = 2'b01;
  localparam logic [1:0] OP_LUMA  = 2'b10;
  localparam logic [1:0] OP_RUN   = 2'b11;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
  } pixel_t;

  localparam pixel_t PIXEL_RESET = '{r: 8'h00, g: 8'h00, b: 8'h00, a: 8'hFF};

  // gathered chunk handed to the pixel unit
  typedef struct packed {
    logic [7:0]  tag;
    logic [31:0] bytes;
  } chunk_t;

  // decoded chunk: pixel, its table slot and the number of extra copies
  typedef struct packed {
    pixel_t              px;
    logic [TableAw-1:0]  slot;
    logic [5:0]          repeats;
  } decode_t;

  function automatic logic [2:0] length_of(input logic [7:0] tag);
    logic [2:0] len;
    if (tag == TAG_RGBA) begin
      len = 3'd5;
    end else if (tag == TAG_RGB) begin
      len = 3'd4;
    end else if (tag[7:6] == OP_LUMA) begin
      len = 3'd2;
    end else begin
      len = 3'd1;
    end
    return len;
  endfunction

  // (3r + 5g + 7b + 11a) mod 64; only the low bits survive
  function automatic logic [TableAw-1:0] hash_of(input pixel_t p);
    logic [9:0] h;
    h = 10'(p.r) * 10'd3 + 10'(p.g) * 10'd5 + 10'(p.b) * 10'd7 + 10'(p.a) * 10'd11;
    return h[TableAw-1:0];
  endfunction

endpackage

// File: design/qoi_chunk_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qoi_chunk_decoder_unit: QOI chunk stream decoder
// Byte-wide chunk input, RGBA pixel output with an end-of-chunk flag.
// ----------------------------------------------------------------------------
// Accepts one chunk-stream byte per cycle while gathering a chunk. The byte
// that completes a chunk launches a read of the 64-entry index table; the
// next cycle forms the pixel from the registered table data, writes it back
// at its hash and loads it as the previous pixel, then the pixel is offered
// on the output (1 to 62 times for a run, out_last_pixel on the final copy).
// Input is held off from the closing byte until the last pixel is taken.
// The table read-modify-write goes through a synchronous RAM with a
// registered read, and reads never overlap a pending write to it. After
// reset the table reads as all zeros and the previous pixel is opaque black.
// ----------------------------------------------------------------------------
module qoi_chunk_decoder_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_stream_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic [7:0] out_alpha,
  output logic       out_last_pixel
);
  import qcd_pkg::*;

  typedef enum logic [2:0] {
    S_COLLECT = 3'b001,
    S_FORM    = 3'b010,
    S_EMIT    = 3'b100
  } state_t;

  state_t      state_r, state_nxt;
  logic [2:0]  pos_r, pos_nxt;
  logic [2:0]  len_r, len_nxt;
  logic [7:0]  tag_r, tag_nxt;
  logic [31:0] bytes_r, bytes_nxt;
  pixel_t      prev_r, prev_nxt;
  logic [5:0]  left_r, left_nxt;

  logic        in_fire, out_fire, chunk_done;
  logic [2:0]  pos_inc, cur_len;
  logic [1:0]  byte_idx;
  chunk_t      chunk;
  pixel_t      table_px;
  decode_t     dec;

  assign in_ready = (state_r == S_COLLECT);
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  assign pos_inc    = pos_r + 3'd1;
  assign cur_len    = (pos_r == 3'd0) ? length_of(in_stream_byte) : len_r;
  assign chunk_done = (pos_inc >= cur_len);

  // payload byte k (position k + 1) lands at bits 8k..8k+7
  assign byte_idx = pos_r[1:0] - 2'd1;

  assign chunk.tag   = tag_r;
  assign chunk.bytes = bytes_r;

  // read at the closing byte: for an INDEX chunk that byte is the tag itself
  qcd_index_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (state_r == S_FORM),
    .wr_addr (dec.slot),
    .wr_data (dec.px),
    .rd_en   (in_fire && chunk_done),
    .rd_addr (in_stream_byte[TableAw-1:0]),
    .rd_data (table_px)
  );

  qcd_pixel_unit u_pixel (
    .chunk    (chunk),
    .prev     (prev_r),
    .table_px (table_px),
    .result   (dec)
  );

  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    len_nxt   = len_r;
    tag_nxt   = tag_r;
    bytes_nxt = bytes_r;
    prev_nxt  = prev_r;
    left_nxt  = left_r;
    unique case (state_r)
      S_COLLECT: begin
        if (in_fire) begin
          if (pos_r == 3'd0) begin
            tag_nxt   = in_stream_byte;
            len_nxt   = cur_len;
            bytes_nxt = '0;
          end else begin
            bytes_nxt[{byte_idx, 3'b000} +: 8] = in_stream_byte;
          end
          if (chunk_done) begin
            pos_nxt   = '0;
            state_nxt = S_FORM;
          end else begin
            pos_nxt = pos_inc;
          end
        end
      end
      S_FORM: begin
        prev_nxt  = dec.px;
        left_nxt  = dec.repeats;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_fire) begin
          if (left_r == '0) begin
            state_nxt = S_COLLECT;
          end else begin
            left_nxt = left_r - 6'd1;
          end
        end
      end
      default: state_nxt = S_COLLECT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_COLLECT;
      pos_r   <= '0;
      len_r   <= '0;
      tag_r   <= '0;
      bytes_r <= '0;
      prev_r  <= PIXEL_RESET;
      left_r  <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      len_r   <= len_nxt;
      tag_r   <= tag_nxt;
      bytes_r <= bytes_nxt;
      prev_r  <= prev_nxt;
      left_r  <= left_nxt;
    end
  end

  assign out_valid      = (state_r == S_EMIT);
  assign out_red        = prev_r.r;
  assign out_green      = prev_r.g;
  assign out_blue       = prev_r.b;
  assign out_alpha      = prev_r.a;
  assign out_last_pixel = (left_r == '0);

endmodule

// File: design/qcd_index_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qcd_index_table: 64-entry pixel index table
// Synchronous RAM, one write and one registered read port; per-entry valid
// bits make unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module qcd_index_table (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    wr_en,
  input  logic [qcd_pkg::TableAw-1:0] wr_addr,
  input  qcd_pkg::pixel_t         wr_data,
  input  logic                    rd_en,
  input  logic [qcd_pkg::TableAw-1:0] rd_addr,
  output qcd_pkg::pixel_t         rd_data
);
  import qcd_pkg::*;

  pixel_t                mem [TableDepth];
  logic [TableDepth-1:0] valid_r;
  pixel_t                rd_data_r;
  logic                  rd_valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_valid_r ? rd_data_r : '0;

endmodule

// File: design/qcd_pixel_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qcd_pixel_unit: chunk to pixel decode
// Forms the new pixel from the gathered chunk, the previous pixel and the
// table entry, plus its hash slot and the run repeat count.
// ----------------------------------------------------------------------------
module qcd_pixel_unit (
  input  qcd_pkg::chunk_t  chunk,
  input  qcd_pkg::pixel_t  prev,
  input  qcd_pkg::pixel_t  table_px,
  output qcd_pkg::decode_t result
);
  import qcd_pkg::*;

  pixel_t     px;
  logic [5:0] repeats;
  logic [7:0] dg;
  logic [7:0] second;

  assign second = chunk.bytes[7:0];
  assign dg     = {2'b00, chunk.tag[5:0]} - 8'd32;

  always_comb begin
    px      = prev;
    repeats = '0;
    if (chunk.tag == TAG_RGB || chunk.tag == TAG_RGBA) begin
      px.r = chunk.bytes[7:0];
      px.g = chunk.bytes[15:8];
      px.b = chunk.bytes[23:16];
      if (chunk.tag == TAG_RGBA) begin
        px.a = chunk.bytes[31:24];
      end
    end else begin
      unique case (chunk.tag[7:6])
        OP_INDEX: px = table_px;
        OP_DIFF: begin
          px.r = prev.r + {6'b0, chunk.tag[5:4]} - 8'd2;
          px.g = prev.g + {6'b0, chunk.tag[3:2]} - 8'd2;
          px.b = prev.b + {6'b0, chunk.tag[1:0]} - 8'd2;
        end
        OP_LUMA: begin
          px.g = prev.g + dg;
          px.r = prev.r + dg + {4'b0, second[7:4]} - 8'd8;
          px.b = prev.b + dg + {4'b0, second[3:0]} - 8'd8;
        end
        OP_RUN: repeats = chunk.tag[5:0];
        default: px = prev;
      endcase
    end
  end

  assign result.px      = px;
  assign result.slot    = hash_of(px);
  assign result.repeats = repeats;

endmodule

// File: design/qcd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qcd_checker: port-level checks for the QOI chunk decoder
// Watches the handshake ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module qcd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue,
  input logic [7:0] out_alpha,
  input logic       out_last_pixel
);

  // input is held off while pixels are pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while output valid");

  // a stalled pixel keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_red) && $stable(out_green)
      && $stable(out_blue) && $stable(out_alpha) && $stable(out_last_pixel))
    else $error("output transaction changed while stalled");

  // a run keeps going until its flagged copy
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_pixel |=> out_valid)
    else $error("run ended without last pixel");

  // after the last pixel of a chunk the input opens again
  a_reopen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last_pixel |=> in_ready && !out_valid)
    else $error("input not reopened after last pixel");

  // no pixel appears in the cycle after an input transaction
  a_form_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !out_valid)
    else $error("pixel without decode cycle");

endmodule

bind qoi_chunk_decoder_unit qcd_checker u_qcd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_red        (out_red),
  .out_green      (out_green),
  .out_blue       (out_blue),
  .out_alpha      (out_alpha),
  .out_last_pixel (out_last_pixel)
);
